// File: src/lhist_pkg.sv
package lhist_pkg;

  localparam int LETTERS   = 26;
  localparam int CNT_W     = 10;
  localparam int IDX_W     = 5;
  localparam int TOP_RESET = 5;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam count_t COUNT_MAX = {CNT_W{1'b1}};
  localparam idx_t   LAST_IDX  = IDX_W'(LETTERS - 1);
  localparam idx_t   NUM_LETTERS = IDX_W'(LETTERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_CLEAR
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic count_en;
    logic scan;
    logic emit;
    logic clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic last_report;
    logic no_report;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic hit;
    idx_t idx;
  } letter_t;

  // Map a byte to its letter number, case-insensitive
  function automatic letter_t letter_of(logic [7:0] byte_in);
    letter_t r;
    r.hit = 1'b0;
    r.idx = '0;
    if (byte_in >= 8'h61 && byte_in <= 8'h7a) begin
      r.hit = 1'b1;
      r.idx = IDX_W'(byte_in - 8'h61);
    end else if (byte_in >= 8'h41 && byte_in <= 8'h5a) begin
      r.hit = 1'b1;
      r.idx = IDX_W'(byte_in - 8'h41);
    end
    return r;
  endfunction

endpackage

// File: src/lhist_ctrl.sv
module lhist_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                end_of_text,
  input  lhist_pkg::sts_t     sts,
  output lhist_pkg::cmd_t     cmd,
  output logic                in_stall
);
  import lhist_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.count_en = in_valid;
        if (in_valid && end_of_text) begin
          state_next = sts.no_report ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.last_report ? ST_CLEAR : ST_SCAN;
        end
      end
      ST_CLEAR: begin
        cmd.clear  = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/lhist_dp.sv
module lhist_dp (
  input  logic                clk,
  input  logic                rst,
  input  lhist_pkg::cmd_t     cmd,
  output lhist_pkg::sts_t     sts,
  input  logic [7:0]          char_code,
  input  logic                cfg_valid,
  input  logic [4:0]          cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [4:0]          letter_index,
  output logic [9:0]          letter_count,
  output logic                final_result
);
  import lhist_pkg::*;

  count_t  counts [LETTERS];
  idx_t    top_count;
  idx_t    reported;
  idx_t    scan_idx;
  idx_t    best_idx;
  count_t  best_cnt;
  idx_t    n_eff;
  count_t  cnt_sel;
  letter_t lt;
  logic    any_count;

  assign lt      = letter_of(char_code);
  assign n_eff   = (top_count > NUM_LETTERS) ? NUM_LETTERS : top_count;
  assign cnt_sel = counts[scan_idx];

  assign sts.scan_done   = (scan_idx == LAST_IDX);
  assign sts.last_report = (reported + 1'b1 == n_eff);
  assign sts.no_report   = (n_eff == '0);
  assign sts.out_free    = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_count <= IDX_W'(TOP_RESET);
    end else if (cfg_valid) begin
      top_count <= cfg_data;
    end
  end

  // One counter per letter
  always_ff @(posedge clk) begin
    for (int i = 0; i < LETTERS; i++) begin
      if (rst || cmd.clear) begin
        counts[i] <= '0;
      end else if (cmd.emit && best_idx == IDX_W'(i)) begin
        counts[i] <= '0;
      end else if (cmd.count_en && lt.hit && lt.idx == IDX_W'(i) &&
                   counts[i] != COUNT_MAX) begin
        counts[i] <= counts[i] + 1'b1;
      end
    end
  end

  // Linear max scan, strict compare keeps the lowest letter on ties
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      scan_idx <= '0;
    end else if (cmd.scan) begin
      scan_idx <= sts.scan_done ? '0 : scan_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan && (scan_idx == '0 || cnt_sel > best_cnt)) begin
      best_idx <= scan_idx;
      best_cnt <= cnt_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      reported <= '0;
    end else if (cmd.emit) begin
      reported <= reported + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      letter_index <= best_idx;
      letter_count <= best_cnt;
      final_result <= sts.last_report;
    end
  end

  always_comb begin
    any_count = 1'b0;
    for (int i = 0; i < LETTERS; i++) begin
      any_count = any_count | (counts[i] != '0);
    end
  end

  a_emit_scan_wrapped: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> scan_idx == '0)
    else $error("result taken before scan wrapped");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> reported < n_eff)
    else $error("more results than requested");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> !any_count && reported == '0)
    else $error("counters not cleared");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("output register overwritten");

endmodule

// File: src/letter_histogram_top_n_top.sv
// Counting: one byte per cycle, accepted whenever the block is idle.
// Report: for each reported letter, a linear scan of all 26 counters, then the
//   output register is loaded; the load waits while the full output register stalls.
// After the last letter, the clear state empties all counters; the next text may then start.
// Reset (synchronous, active high): counters cleared, top_count set to 5,
//   output register empty.
module letter_histogram_top_n_top (
  input  logic       clk,
  input  logic       rst,
  // byte stream
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       end_of_text,
  // result stream
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] letter_index,
  output logic [9:0] letter_count,
  output logic       final_result,
  // top_count register write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);
  import lhist_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The register takes a write transaction in any cycle; software must write it
  // only between texts, and the block itself does not enforce this.
  assign cfg_ready = 1'b1;

  // Controller: sequence count, scan, emit and clear phases.
  lhist_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .end_of_text (end_of_text),
    .sts         (sts),
    .cmd         (cmd),
    .in_stall    (in_stall)
  );

  // Datapath: letter counters, max scan and the output register.
  lhist_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .char_code    (char_code),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .letter_index (letter_index),
    .letter_count (letter_count),
    .final_result (final_result)
  );

endmodule
